>>> src/sbd_pkg.sv
// Shared types and constants for the SBUS frame decoder.
// No dependencies; every other file in src imports this package.
package sbd_pkg;

  localparam int FRAME_LEN  = 25;
  localparam int POS_W      = 5;
  localparam int VAL_W      = 11;
  localparam int CNT_W      = 16;
  localparam int IDX_W      = 3;
  localparam int DATA_BYTES = 11;
  localparam int DATA_W     = 8 * DATA_BYTES;
  localparam int FLAG_POS   = FRAME_LEN - 2;
  localparam int END_POS    = FRAME_LEN - 1;

  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE   = 8'h00;
  localparam logic [3:0] END_NIBBLE = 4'h4;
  localparam int FAILSAFE_BIT = 3;
  localparam int LOST_BIT     = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(16'h0001);

  localparam logic [1:0] CLASS_LOW    = 2'd0;
  localparam logic [1:0] CLASS_CENTER = 2'd1;
  localparam logic [1:0] CLASS_HIGH   = 2'd2;
  localparam logic [1:0] CLASS_EDGE   = 2'd3;

  localparam logic [VAL_W-1:0] MIN_RST  = VAL_W'(172);
  localparam logic [VAL_W-1:0] MAX_RST  = VAL_W'(1811);
  localparam logic [VAL_W-1:0] LOW_RST  = VAL_W'(700);
  localparam logic [VAL_W-1:0] HIGH_RST = VAL_W'(1300);

  typedef struct packed {
    logic [VAL_W-1:0] ch_min;
    logic [VAL_W-1:0] ch_max;
    logic [VAL_W-1:0] low_thr;
    logic [VAL_W-1:0] high_thr;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              failsafe;
    logic              lost;
    logic [CNT_W-1:0]  skipped;
    logic [CNT_W-1:0]  errors;
    logic [CNT_W-1:0]  lost_cnt;
  } job_t;

  function automatic logic is_end_mark(logic [7:0] b);
    return (b == END_BYTE) || (b[3:0] == END_NIBBLE);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_ONE;
  endfunction

endpackage

>>> src/sbd_front.sv
// Front end: frame sync, byte capture and saturating counters.
// Hands each good frame to the job queue. Depends on sbd_pkg.
module sbd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output sbd_pkg::job_t       q_job_o
);
  import sbd_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [7:0]        prev_q;
  logic [DATA_W-1:0] data_q;
  logic [7:0]        flags_q;
  logic [CNT_W-1:0]  skip_q, skip_d;
  logic [CNT_W-1:0]  err_q, err_d;
  logic [CNT_W-1:0]  lost_q, lost_d;
  logic              at_end;
  logic              accept;
  logic              good_end;

  assign at_end     = (pos_q >= POS_W'(END_POS));
  assign in_ready_o = !at_end || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign good_end   = at_end && is_end_mark(rx_byte_i);
  assign q_push_o   = accept && good_end;

  always_comb begin
    pos_d  = pos_q;
    skip_d = skip_q;
    err_d  = err_q;
    lost_d = lost_q;
    if (pos_q == '0) begin
      if (rx_byte_i == START_BYTE && is_end_mark(prev_q)) begin
        pos_d = POS_W'(1);
      end else begin
        skip_d = sat_inc(skip_q);
      end
    end else if (!at_end) begin
      pos_d = pos_q + POS_W'(1);
    end else begin
      pos_d = '0;
      if (good_end) begin
        if (flags_q[LOST_BIT]) lost_d = sat_inc(lost_q);
      end else begin
        err_d = sat_inc(err_q);
      end
    end
  end

  assign q_job_o = '{data:     data_q,
                     failsafe: flags_q[FAILSAFE_BIT],
                     lost:     flags_q[LOST_BIT],
                     skipped:  skip_q,
                     errors:   err_q,
                     lost_cnt: lost_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      prev_q <= END_BYTE;
      skip_q <= '0;
      err_q  <= '0;
      lost_q <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      prev_q <= rx_byte_i;
      skip_q <= skip_d;
      err_q  <= err_d;
      lost_q <= lost_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int j = 1; j <= DATA_BYTES; j++) begin
        if (pos_q == POS_W'(j)) data_q[8*(j-1) +: 8] <= rx_byte_i;
      end
      if (pos_q == POS_W'(FLAG_POS)) flags_q <= rx_byte_i;
    end
  end

endmodule

>>> src/sbd_queue.sv
// Two-entry job queue between the front end and the channel emitter.
// Depends on sbd_pkg for the job type.
module sbd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sbd_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output sbd_pkg::job_t head_o
);
  import sbd_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_job_i;
  end

endmodule

>>> src/sbd_back.sv
// Back end: unpacks, clamps and classes one channel per cycle while the output
// is free or ready, from the queue head into the output register. Needs sbd_pkg.
module sbd_back #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sbd_pkg::cfg_t               cfg_i,
  input  logic                        q_valid_i,
  input  sbd_pkg::job_t               q_head_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sbd_pkg::IDX_W-1:0]   channel_index_o,
  output logic [sbd_pkg::VAL_W-1:0]   channel_value_o,
  output logic [1:0]                  position_class_o,
  output logic                        failsafe_o,
  output logic                        frame_lost_o,
  output logic [sbd_pkg::CNT_W-1:0]   skipped_starts_o,
  output logic [sbd_pkg::CNT_W-1:0]   decode_errors_o,
  output logic [sbd_pkg::CNT_W-1:0]   lost_count_o,
  output logic                        last_of_frame_o
);
  import sbd_pkg::*;

  localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(NUM_CHANNELS - 1);

  logic [IDX_W-1:0] ch_q;
  logic             out_valid_q;
  logic             load;
  logic             is_last;
  logic [VAL_W-1:0] raw;
  logic [VAL_W-1:0] val;
  logic [1:0]       cls;

  assign load    = q_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = (ch_q == LAST_CH);
  assign q_pop_o = load && is_last;
  assign raw     = q_head_i.data[VAL_W*ch_q +: VAL_W];

  always_comb begin
    if (raw < cfg_i.ch_min) begin
      val = cfg_i.ch_min;
    end else if (raw > cfg_i.ch_max) begin
      val = cfg_i.ch_max;
    end else begin
      val = raw;
    end
    if (val < cfg_i.low_thr) begin
      cls = CLASS_LOW;
    end else if (cfg_i.low_thr < val && val < cfg_i.high_thr) begin
      cls = CLASS_CENTER;
    end else if (cfg_i.high_thr < val) begin
      cls = CLASS_HIGH;
    end else begin
      cls = CLASS_EDGE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        ch_q        <= is_last ? '0 : ch_q + IDX_W'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      channel_index_o  <= ch_q;
      channel_value_o  <= val;
      position_class_o <= cls;
      failsafe_o       <= q_head_i.failsafe;
      frame_lost_o     <= q_head_i.lost;
      skipped_starts_o <= q_head_i.skipped;
      decode_errors_o  <= q_head_i.errors;
      lost_count_o     <= q_head_i.lost_cnt;
      last_of_frame_o  <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/sbus_frame_decoder.sv
// SBUS frame decoder top level: configuration registers and the front,
// queue and back instances. Depends on sbd_pkg, sbd_front, sbd_queue, sbd_back.
//
// The decoder takes one received byte per cycle unless stalled. A frame starts
// on a 0x0F byte whose predecessor is 0x00 or has low nibble 0x04, and the
// 25th byte is checked as the end byte. A good frame is handed to a two-entry
// queue, and the emitter then delivers NUM_CHANNELS results, one per cycle while
// the output is ready; once the end byte is taken, the first result passes from
// the queue head into the output register. Each result is clamped to
// channel_min/channel_max and classed against the two thresholds. Input stalls
// only on an end byte while the queue holds two frames not yet emitted.
// Counters in each result are those in force after the frame's end byte.
module sbus_frame_decoder #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sbd_pkg::IDX_W-1:0]   channel_index_o,
  output logic [sbd_pkg::VAL_W-1:0]   channel_value_o,
  output logic [1:0]                  position_class_o,
  output logic                        failsafe_o,
  output logic                        frame_lost_o,
  output logic [sbd_pkg::CNT_W-1:0]   skipped_starts_o,
  output logic [sbd_pkg::CNT_W-1:0]   decode_errors_o,
  output logic [sbd_pkg::CNT_W-1:0]   lost_count_o,
  output logic                        last_of_frame_o
);
  import sbd_pkg::*;

  localparam logic [1:0] REG_MIN  = 2'd0;
  localparam logic [1:0] REG_MAX  = 2'd1;
  localparam logic [1:0] REG_LOW  = 2'd2;
  localparam logic [1:0] REG_HIGH = 2'd3;

  cfg_t             cfg_q;
  logic             wr_en;
  logic [1:0]       reg_idx;
  logic [VAL_W-1:0] rd_val;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_valid;
  job_t             push_job;
  job_t             head_job;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{ch_min: MIN_RST, ch_max: MAX_RST, low_thr: LOW_RST, high_thr: HIGH_RST};
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN:  cfg_q.ch_min   <= pwdata[VAL_W-1:0];
        REG_MAX:  cfg_q.ch_max   <= pwdata[VAL_W-1:0];
        REG_LOW:  cfg_q.low_thr  <= pwdata[VAL_W-1:0];
        REG_HIGH: cfg_q.high_thr <= pwdata[VAL_W-1:0];
        default:  cfg_q          <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN:  rd_val = cfg_q.ch_min;
      REG_MAX:  rd_val = cfg_q.ch_max;
      REG_LOW:  rd_val = cfg_q.low_thr;
      REG_HIGH: rd_val = cfg_q.high_thr;
      default:  rd_val = '0;
    endcase
  end

  assign prdata = {{(32-VAL_W){1'b0}}, rd_val};

  sbd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  sbd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  sbd_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_valid_i        (q_valid),
    .q_head_i         (head_job),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .channel_index_o  (channel_index_o),
    .channel_value_o  (channel_value_o),
    .position_class_o (position_class_o),
    .failsafe_o       (failsafe_o),
    .frame_lost_o     (frame_lost_o),
    .skipped_starts_o (skipped_starts_o),
    .decode_errors_o  (decode_errors_o),
    .lost_count_o     (lost_count_o),
    .last_of_frame_o  (last_of_frame_o)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for sbus_frame_decoder: a byte stream driver, an APB
// register writer and a frame scoreboard that predicts every channel word.
// Depends on sbd_pkg and the decoder RTL in src.
module tb_top;
  import sbd_pkg::*;

  localparam int N_CH       = 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYC = 24;

  localparam int REG_CH_MIN   = 0;
  localparam int REG_CH_MAX   = 1;
  localparam int REG_LOW_THR  = 2;
  localparam int REG_HIGH_THR = 3;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    logic [1:0]       cls;
    logic             failsafe;
    logic             lost;
    logic [CNT_W-1:0] skipped;
    logic [CNT_W-1:0] errors;
    logic [CNT_W-1:0] lost_cnt;
    logic             last;
  } chan_word_t;

  class frame_scoreboard;
    logic [7:0]       frame_buf [FRAME_LEN-1];
    int unsigned      fill;
    logic [7:0]       last_byte;
    logic [CNT_W-1:0] skipped, errors, lost_cnt;
    logic [VAL_W-1:0] lo_clamp, hi_clamp, low_thr, high_thr;
    chan_word_t       channel_q [$];
    int unsigned      failures, bytes_seen, good_frames, bad_ends, words_checked;

    function new();
      lo_clamp  = MIN_RST;
      hi_clamp  = MAX_RST;
      low_thr   = LOW_RST;
      high_thr  = HIGH_RST;
      fill      = 0;
      last_byte = END_BYTE;
      skipped   = '0;
      errors    = '0;
      lost_cnt  = '0;
    endfunction

    function void set_reg(int idx, logic [31:0] data);
      case (idx)
        REG_CH_MIN:   lo_clamp = data[VAL_W-1:0];
        REG_CH_MAX:   hi_clamp = data[VAL_W-1:0];
        REG_LOW_THR:  low_thr  = data[VAL_W-1:0];
        REG_HIGH_THR: high_thr = data[VAL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic ends_frame(logic [7:0] b);
      return (b == END_BYTE) || (b[3:0] == END_NIBBLE);
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function logic [1:0] position_of(logic [VAL_W-1:0] v);
      if (v < low_thr) return CLASS_LOW;
      if (v > low_thr && v < high_thr) return CLASS_CENTER;
      if (v > high_thr) return CLASS_HIGH;
      return CLASS_EDGE;
    endfunction

    function void decode_frame();
      logic [DATA_W-1:0] bits;
      logic [VAL_W-1:0]  raw, v;
      chan_word_t        w;
      for (int i = 0; i < DATA_BYTES; i++) bits[8*i +: 8] = frame_buf[i+1];
      w.failsafe = frame_buf[FLAG_POS][FAILSAFE_BIT];
      w.lost     = frame_buf[FLAG_POS][LOST_BIT];
      if (w.lost) lost_cnt = bump(lost_cnt);
      for (int k = 0; k < N_CH; k++) begin
        raw = bits[VAL_W*k +: VAL_W];
        if (raw < lo_clamp) v = lo_clamp;
        else if (raw > hi_clamp) v = hi_clamp;
        else v = raw;
        w.idx      = k[IDX_W-1:0];
        w.value    = v;
        w.cls      = position_of(v);
        w.skipped  = skipped;
        w.errors   = errors;
        w.lost_cnt = lost_cnt;
        w.last     = (k == N_CH - 1);
        channel_q.push_back(w);
      end
      good_frames++;
    endfunction

    function void take_byte(logic [7:0] b);
      bytes_seen++;
      if (fill == 0) begin
        if (b == START_BYTE && ends_frame(last_byte)) begin
          frame_buf[0] = b;
          fill = 1;
        end else begin
          skipped = bump(skipped);
        end
      end else if (fill < FRAME_LEN - 1) begin
        frame_buf[fill] = b;
        fill++;
      end else begin
        fill = 0;
        if (ends_frame(b)) begin
          decode_frame();
        end else begin
          errors = bump(errors);
          bad_ends++;
        end
      end
      last_byte = b;
    endfunction

    function void cmp(string name, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
        failures++;
      end
    endfunction

    function void check_word(chan_word_t got);
      chan_word_t exp_w;
      if (channel_q.size() == 0) begin
        $display("%0t: unexpected channel word, expected none, got index %0d value %0d",
                 $time, got.idx, got.value);
        failures++;
        return;
      end
      exp_w = channel_q.pop_front();
      words_checked++;
      cmp("channel_index", exp_w.idx, got.idx);
      cmp("channel_value", exp_w.value, got.value);
      cmp("position_class", exp_w.cls, got.cls);
      cmp("failsafe", exp_w.failsafe, got.failsafe);
      cmp("frame_lost", exp_w.lost, got.lost);
      cmp("skipped_starts", exp_w.skipped, got.skipped);
      cmp("decode_errors", exp_w.errors, got.errors);
      cmp("lost_count", exp_w.lost_cnt, got.lost_cnt);
      cmp("last_of_frame", exp_w.last, got.last);
    endfunction
  endclass

  logic             clk_i, rst_ni;
  logic             psel, penable, pwrite, pready;
  logic [3:0]       paddr;
  logic [31:0]      pwdata, prdata;
  logic             in_valid_i, in_ready_o;
  logic [7:0]       rx_byte_i;
  logic             out_valid_o, out_ready_i;
  logic [IDX_W-1:0] channel_index_o;
  logic [VAL_W-1:0] channel_value_o;
  logic [1:0]       position_class_o;
  logic             failsafe_o, frame_lost_o, last_of_frame_o;
  logic [CNT_W-1:0] skipped_starts_o, decode_errors_o, lost_count_o;

  frame_scoreboard sb;
  bit              calm;
  int              idle_cycles;
  chan_word_t      got_word;

  sbus_frame_decoder #(.NUM_CHANNELS(N_CH)) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .channel_index_o  (channel_index_o),
    .channel_value_o  (channel_value_o),
    .position_class_o (position_class_o),
    .failsafe_o       (failsafe_o),
    .frame_lost_o     (frame_lost_o),
    .skipped_starts_o (skipped_starts_o),
    .decode_errors_o  (decode_errors_o),
    .lost_count_o     (lost_count_o),
    .last_of_frame_o  (last_of_frame_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_byte(b);
  endtask

  task automatic send_frame(input logic [VAL_W-1:0] ch [N_CH], input logic [7:0] flags,
                            input logic [7:0] end_b);
    logic [DATA_W-1:0] bits;
    for (int k = 0; k < N_CH; k++) bits[VAL_W*k +: VAL_W] = ch[k];
    send_byte(START_BYTE);
    for (int i = 0; i < DATA_BYTES; i++) send_byte(bits[8*i +: 8]);
    for (int i = DATA_BYTES + 1; i < FLAG_POS; i++) send_byte(8'($urandom()));
    send_byte(flags);
    send_byte(end_b);
  endtask

  task automatic write_reg(input int idx, input logic [VAL_W-1:0] val);
    logic [31:0] data;
    data = ($urandom() & ~32'h7FF) | 32'(val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(4 * idx);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic apply_config(input logic [VAL_W-1:0] mn, input logic [VAL_W-1:0] mx,
                              input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi);
    write_reg(REG_CH_MIN, mn);
    write_reg(REG_CH_MAX, mx);
    write_reg(REG_LOW_THR, lo);
    write_reg(REG_HIGH_THR, hi);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.channel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return sb.low_thr;
      3: return sb.high_thr;
      4: return sb.low_thr + VAL_W'($urandom_range(0, 2)) - 1'b1;
      5: return sb.high_thr + VAL_W'($urandom_range(0, 2)) - 1'b1;
      6: return $urandom_range(0, 1) ? sb.lo_clamp : sb.hi_clamp;
      default: return VAL_W'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic logic [7:0] pick_end();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return END_BYTE;
    if (r < 9) return {4'($urandom_range(0, 15)), END_NIBBLE};
    return 8'($urandom());
  endfunction

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_byte(8'($urandom()));
    if ($urandom_range(0, 1)) send_byte(END_BYTE);
  endtask

  task automatic run_traffic(input int n_frames);
    logic [VAL_W-1:0] ch [N_CH];
    repeat (n_frames) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) send_noise();
      if ($urandom_range(0, 9) == 0) begin
        send_byte(START_BYTE);
        repeat ($urandom_range(1, 20)) send_byte(8'($urandom()));
        send_byte(END_BYTE);
      end
      for (int k = 0; k < N_CH; k++) ch[k] = pick_value();
      send_frame(ch, 8'($urandom()), pick_end());
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_word.idx      = channel_index_o;
      got_word.value    = channel_value_o;
      got_word.cls      = position_class_o;
      got_word.failsafe = failsafe_o;
      got_word.lost     = frame_lost_o;
      got_word.skipped  = skipped_starts_o;
      got_word.errors   = decode_errors_o;
      got_word.lost_cnt = lost_count_o;
      got_word.last     = last_of_frame_o;
      sb.check_word(got_word);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap(1'b0);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6))
        @(posedge clk_i);
    end
  end

  initial begin
    logic [VAL_W-1:0] ch [N_CH];
    sb = new();
    idle_cycles <= 0;
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    rx_byte_i   <= '0;
    out_ready_i <= 1'b0;
    calm        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hunt past a start byte with a bad predecessor, then sync on a 0x?4 byte
    send_byte(8'h05);
    send_byte(START_BYTE);
    send_byte(8'h14);
    ch = '{11'd0, 11'd2047, 11'd700, 11'd1300, 11'd699, 11'd701, 11'd1299, 11'd1301};
    send_frame(ch, 8'h00, END_BYTE);
    ch = '{11'd172, 11'd1811, 11'd171, 11'd1812, 11'd1000, 11'h555, 11'h2AA, 11'd1};
    send_frame(ch, 8'hFC, 8'hF4);
    send_frame(ch, 8'h08, 8'h0F);
    send_byte(END_BYTE);
    send_frame(ch, 8'h04, END_BYTE);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_config('0, '1, '0, '1);
        1: apply_config('1, '0, '1, '0);
        2: apply_config(11'd1500, 11'd300, 11'd1024, 11'd1024);
        3, 4: apply_config(VAL_W'($urandom_range(0, 1023)), VAL_W'($urandom_range(1024, 2047)),
                           VAL_W'($urandom_range(0, 2047)), VAL_W'($urandom_range(0, 2047)));
        default: apply_config(MIN_RST, MAX_RST, LOW_RST, HIGH_RST);
      endcase
      run_traffic(1);
      settle();
    end

    // decode one more frame back to back with both flags set
    calm = 1'b1;
    send_byte(END_BYTE);
    for (int k = 0; k < N_CH; k++) ch[k] = pick_value();
    send_frame(ch, 8'h0C, END_BYTE);
    settle();

    $display("%0d bytes driven, %0d good frames, %0d bad end bytes, %0d channel words checked",
             sb.bytes_seen, sb.good_frames, sb.bad_ends, sb.words_checked);
    $display("settings: reset, extremes, inverted clamp and thresholds, equal thresholds, random");
    if (sb.failures == 0 && sb.channel_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
